// ===== rtl/core/pcef_pkg.sv =====
`default_nettype none

package pcef_pkg;

    localparam int DEFAULT_EVENT_DEPTH = 16;
    localparam int DEFAULT_PORT_COUNT  = 4;
    localparam int MASK_REGS           = 4;

    localparam int MODE_W   = 2;
    localparam int PORT_W   = 2;
    localparam int LEVEL_W  = 8;
    localparam int TIME_W   = 32;
    localparam int OCC_W    = 5;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_POP    = 2'd1,
        MODE_RESYNC = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [PORT_W-1:0]  port;
        logic [LEVEL_W-1:0] changes;
        logic [LEVEL_W-1:0] levels;
    } event_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcef_ifs.sv =====
`default_nettype none

interface pcef_item_if;
    logic                          valid;
    logic                          ready;
    logic [pcef_pkg::MODE_W-1:0]   mode;
    logic [pcef_pkg::PORT_W-1:0]   port_index;
    logic [pcef_pkg::LEVEL_W-1:0]  pin_levels;
    logic [pcef_pkg::LEVEL_W-1:0]  resync_mask;
    logic [pcef_pkg::TIME_W-1:0]   sample_time;

    modport source (output valid, mode, port_index, pin_levels, resync_mask, sample_time,
                    input ready);
    modport sink   (input valid, mode, port_index, pin_levels, resync_mask, sample_time,
                    output ready);
endinterface

interface pcef_result_if;
    logic                          valid;
    logic                          ready;
    logic [pcef_pkg::OCC_W-1:0]    occupancy;
    logic                          event_valid;
    logic [pcef_pkg::TIME_W-1:0]   event_time;
    logic [pcef_pkg::PORT_W-1:0]   event_port;
    logic [pcef_pkg::LEVEL_W-1:0]  event_changes;
    logic [pcef_pkg::LEVEL_W-1:0]  event_levels;

    modport source (output valid, occupancy, event_valid, event_time, event_port,
                    event_changes, event_levels, input ready);
    modport sink   (input valid, occupancy, event_valid, event_time, event_port,
                    event_changes, event_levels, output ready);
endinterface

interface pcef_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pcef_pkg::CFG_IDX_W-1:0]  index;
    logic [pcef_pkg::LEVEL_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pcef_ring.sv =====
`default_nettype none

module pcef_ring #(
    parameter int EVENT_DEPTH = pcef_pkg::DEFAULT_EVENT_DEPTH,
    localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire pcef_pkg::event_t wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output pcef_pkg::event_t      rd_data
);

    pcef_pkg::event_t mem [EVENT_DEPTH];
    pcef_pkg::event_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pin_change_event_fifo.sv =====
// A sample, resync or ignored transaction writes its result into the result register on acceptance;
// a pop first reads the registered ring memory in the read state, then fills the result register.
// One transaction per cycle while result.ready holds; a pop blocks new transactions during its
// ring read. A new one is taken in idle while the result register is empty or draining.
// Reset clears the listen masks, stored levels, head pointer and event count; the ring
// memory itself is not cleared and needs no clearing pass.
`default_nettype none

module pin_change_event_fifo #(
    parameter int EVENT_DEPTH = pcef_pkg::DEFAULT_EVENT_DEPTH,
    parameter int PORT_COUNT  = pcef_pkg::DEFAULT_PORT_COUNT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pcef_cfg_if.sink       cfg,
    pcef_item_if.sink      item,
    pcef_result_if.source  result
);

    localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int LW = pcef_pkg::LEVEL_W;

    pcef_pkg::state_t state_reg, state_next;

    logic [LW-1:0] mask_reg [PORT_COUNT];
    logic [LW-1:0] last_reg [PORT_COUNT];
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    logic                        out_valid_reg, out_valid_next;
    logic [pcef_pkg::OCC_W-1:0]  occ_reg;
    pcef_pkg::event_t            ev_reg;
    logic                        ev_valid_reg;

    logic                        accept;
    pcef_pkg::mode_t             mode;
    logic                        port_ok;
    logic [LW-1:0]               mask_sel;
    logic [LW-1:0]               last_sel;
    logic [LW-1:0]               changed;
    logic                        do_write;
    logic                        do_pop;
    logic [SW-1:0]               tail_sum;
    logic [AW-1:0]               tail;
    logic [AW-1:0]               head_inc;
    pcef_pkg::event_t            wr_data;
    pcef_pkg::event_t            rd_data;

    assign cfg.ready = 1'b1;
    assign mode      = pcef_pkg::mode_t'(item.mode);
    assign item.ready = (state_reg == pcef_pkg::ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept    = item.valid && item.ready;

    always_comb
    begin
        port_ok  = 1'b0;
        mask_sel = '0;
        last_sel = '0;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            if (4'(item.port_index) == 4'(p))
            begin
                port_ok  = 1'b1;
                mask_sel = mask_reg[p];
                last_sel = last_reg[p];
            end
        end
    end

    assign changed  = mask_sel & (last_sel ^ item.pin_levels);
    assign do_write = accept && (mode == pcef_pkg::MODE_SAMPLE) && port_ok
                      && (mask_sel != '0) && (changed != '0);
    assign do_pop   = accept && (mode == pcef_pkg::MODE_POP) && (count_reg != '0);

    assign tail_sum = {1'b0, head_reg} + SW'(count_reg);
    assign tail     = (tail_sum >= SW'(EVENT_DEPTH)) ? AW'(tail_sum - SW'(EVENT_DEPTH))
                                                      : AW'(tail_sum);
    assign head_inc = (head_reg == AW'(EVENT_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    assign wr_data.stamp   = item.sample_time;
    assign wr_data.port    = item.port_index;
    assign wr_data.changes = changed;
    assign wr_data.levels  = item.pin_levels;

    pcef_ring #(
        .EVENT_DEPTH(EVENT_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (tail),
        .wr_data (wr_data),
        .rd_en   (do_pop),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            pcef_pkg::ST_IDLE:
            begin
                if (do_write)
                begin
                    if (count_reg == CW'(EVENT_DEPTH))
                    begin
                        head_next = head_inc;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                if (do_pop)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                    state_next = pcef_pkg::ST_READ;
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                end
            end
            pcef_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                state_next     = pcef_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcef_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcef_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                mask_reg[p] <= '0;
                last_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                if (cfg.valid && (cfg.index == pcef_pkg::CFG_IDX_W'(p))
                    && (p < pcef_pkg::MASK_REGS))
                begin
                    mask_reg[p] <= cfg.data;
                end
                if (accept && (4'(item.port_index) == 4'(p)))
                begin
                    if ((mode == pcef_pkg::MODE_SAMPLE) && (mask_reg[p] != '0))
                    begin
                        last_reg[p] <= item.pin_levels;
                    end
                    else if (mode == pcef_pkg::MODE_RESYNC)
                    begin
                        last_reg[p] <= (last_reg[p] & ~item.resync_mask)
                                       | (item.pin_levels & item.resync_mask);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            occ_reg      <= pcef_pkg::OCC_W'(count_next);
            ev_valid_reg <= 1'b0;
            ev_reg       <= '0;
        end
        else if (state_reg == pcef_pkg::ST_READ)
        begin
            ev_valid_reg <= 1'b1;
            ev_reg       <= rd_data;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.occupancy     = occ_reg;
    assign result.event_valid   = ev_valid_reg;
    assign result.event_time    = ev_reg.stamp;
    assign result.event_port    = ev_reg.port;
    assign result.event_changes = ev_reg.changes;
    assign result.event_levels  = ev_reg.levels;

endmodule

`default_nettype wire

// ===== bench/tb_pin_change_event_fifo.sv =====
`timescale 1ns / 1ps

module tb_pin_change_event_fifo;

    import pcef_pkg::*;

    localparam int EVENT_DEPTH = DEFAULT_EVENT_DEPTH;
    localparam int PORT_COUNT  = DEFAULT_PORT_COUNT;

    typedef struct packed {
        mode_t              mode;
        logic [PORT_W-1:0]  port;
        logic [LEVEL_W-1:0] levels;
        logic [LEVEL_W-1:0] rmask;
        logic [TIME_W-1:0]  stamp;
    } pin_item_t;

    typedef struct packed {
        logic [OCC_W-1:0]   occupancy;
        logic               event_valid;
        logic [TIME_W-1:0]  event_time;
        logic [PORT_W-1:0]  event_port;
        logic [LEVEL_W-1:0] event_changes;
        logic [LEVEL_W-1:0] event_levels;
    } change_report_t;

    logic clk;
    logic rst_n;

    pcef_cfg_if    cfg_ch ();
    pcef_item_if   item_ch ();
    pcef_result_if result_ch ();

    pin_change_event_fifo DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    logic [LEVEL_W-1:0] listen_mask [PORT_COUNT];
    logic [LEVEL_W-1:0] last_seen [PORT_COUNT];
    event_t             ring [EVENT_DEPTH];
    int                 ring_head;
    int                 ring_count;

    change_report_t pending_reports [$];
    change_report_t want;

    int          error_count;
    int          items_sent;
    int          reports_checked;
    int          pops_with_event;
    int          overflow_count;
    int          mask_settings;
    bit          quiet;
    logic [31:0] stamp_clock;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic change_report_t predict_change(input pin_item_t it);
        change_report_t r;
        logic [LEVEL_W-1:0] changed;
        int tail;
        r = '0;
        case (it.mode)
            MODE_SAMPLE:
            begin
                if (it.port < PORT_COUNT && listen_mask[it.port] != '0)
                begin
                    changed = listen_mask[it.port] & (last_seen[it.port] ^ it.levels);
                    if (changed != '0)
                    begin
                        tail = (ring_head + ring_count) % EVENT_DEPTH;
                        ring[tail].stamp   = it.stamp;
                        ring[tail].port    = it.port;
                        ring[tail].changes = changed;
                        ring[tail].levels  = it.levels;
                        if (ring_count < EVENT_DEPTH)
                        begin
                            ring_count++;
                        end
                        else
                        begin
                            ring_head = (ring_head + 1) % EVENT_DEPTH;
                            overflow_count++;
                        end
                    end
                    last_seen[it.port] = it.levels;
                end
            end
            MODE_POP:
            begin
                if (ring_count != 0)
                begin
                    r.event_valid   = 1'b1;
                    r.event_time    = ring[ring_head].stamp;
                    r.event_port    = ring[ring_head].port;
                    r.event_changes = ring[ring_head].changes;
                    r.event_levels  = ring[ring_head].levels;
                    ring_count--;
                    ring_head = (ring_head + 1) % EVENT_DEPTH;
                    pops_with_event++;
                end
            end
            MODE_RESYNC:
            begin
                if (it.port < PORT_COUNT)
                begin
                    last_seen[it.port] = (last_seen[it.port] & ~it.rmask)
                                       | (it.levels & it.rmask);
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(ring_count);
        return r;
    endfunction

    function automatic pin_item_t make_item(input mode_t mode, input logic [PORT_W-1:0] port,
                                            input logic [LEVEL_W-1:0] levels,
                                            input logic [LEVEL_W-1:0] rmask,
                                            input logic [TIME_W-1:0] stamp);
        pin_item_t it;
        it.mode   = mode;
        it.port   = port;
        it.levels = levels;
        it.rmask  = rmask;
        it.stamp  = stamp;
        return it;
    endfunction

    function automatic pin_item_t random_item(input int pop_pct);
        pin_item_t it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < pop_pct)
            it.mode = MODE_POP;
        else if (roll < pop_pct + 8)
            it.mode = MODE_NONE;
        else if (roll < pop_pct + 20)
            it.mode = MODE_RESYNC;
        else
            it.mode = MODE_SAMPLE;
        it.port = PORT_W'($urandom_range(0, PORT_COUNT - 1));
        case ($urandom_range(0, 3))
            0:       it.levels = LEVEL_W'($urandom);
            3:       it.levels = last_seen[it.port] ^ LEVEL_W'($urandom);
            default: it.levels = last_seen[it.port] ^ (8'h01 << $urandom_range(0, 7));
        endcase
        case ($urandom_range(0, 7))
            0:       it.rmask = '0;
            1:       it.rmask = '1;
            default: it.rmask = LEVEL_W'($urandom);
        endcase
        stamp_clock += $urandom_range(0, 50);
        if ($urandom_range(0, 15) == 0)
            it.stamp = $urandom;
        else
            it.stamp = stamp_clock;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] expected);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                 $realtime, what, got, expected, reports_checked);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'(result_ch.occupancy), '0);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result_ch.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(result_ch.occupancy),
                                    32'(want.occupancy));
                if (result_ch.event_valid !== want.event_valid)
                    report_mismatch("event_valid", 32'(result_ch.event_valid),
                                    32'(want.event_valid));
                if (result_ch.event_time !== want.event_time)
                    report_mismatch("event_time", result_ch.event_time, want.event_time);
                if (result_ch.event_port !== want.event_port)
                    report_mismatch("event_port", 32'(result_ch.event_port),
                                    32'(want.event_port));
                if (result_ch.event_changes !== want.event_changes)
                    report_mismatch("event_changes", 32'(result_ch.event_changes),
                                    32'(want.event_changes));
                if (result_ch.event_levels !== want.event_levels)
                    report_mismatch("event_levels", 32'(result_ch.event_levels),
                                    32'(want.event_levels));
                reports_checked++;
            end
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 60)) @(posedge clk);
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input pin_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= it.mode;
        item_ch.port_index  <= it.port;
        item_ch.pin_levels  <= it.levels;
        item_ch.resync_mask <= it.rmask;
        item_ch.sample_time <= it.stamp;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_reports.push_back(predict_change(it));
        items_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        if (item_ch.valid)
            item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_reports.size() != 0)
        begin
            report_mismatch("results never delivered", pending_reports.size(), 0);
            pending_reports.delete();
        end
    endtask

    task automatic set_listen_masks(input logic [PORT_COUNT-1:0][LEVEL_W-1:0] masks,
                                    input bit stray);
        for (int i = 0; i < MASK_REGS; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= CFG_IDX_W'(i);
            cfg_ch.data  <= masks[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            if (i < PORT_COUNT)
                listen_mask[i] = masks[i];
        end
        if (stray)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= CFG_IDX_W'($urandom_range(MASK_REGS, 255));
            cfg_ch.data  <= LEVEL_W'($urandom);
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        mask_settings++;
    endtask

    task automatic test_empty_ring();
        send_item(make_item(MODE_POP, 2'd0, 8'h00, 8'h00, 32'h0));
        send_item(make_item(MODE_SAMPLE, 2'd0, 8'hFF, 8'hFF, 32'h0));
        send_item(make_item(MODE_NONE, 2'd3, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_RESYNC, 2'd1, 8'hFF, 8'hFF, 32'h1234_5678));
        drain_results();
    endtask

    task automatic test_basic_events();
        set_listen_masks({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_IDX_W'(MASK_REGS);
        cfg_ch.data  <= 8'h00;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.index <= '1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        send_item(make_item(MODE_SAMPLE, 2'd0, 8'hFF, 8'h00, 32'hFFFF_FFFF));
        send_item(make_item(MODE_SAMPLE, 2'd3, 8'h00, 8'hFF, 32'h0));
        send_item(make_item(MODE_RESYNC, 2'd3, 8'hA5, 8'hF0, 32'h0));
        send_item(make_item(MODE_SAMPLE, 2'd3, 8'h00, 8'h00, 32'h0000_0001));
        send_item(make_item(MODE_SAMPLE, 2'd1, 8'h01, 8'h00, 32'h8000_0000));
        send_item(make_item(MODE_SAMPLE, 2'd2, 8'h80, 8'h00, 32'h7FFF_FFFF));
        repeat (4)
            send_item(make_item(MODE_POP, 2'd3, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_RESYNC, 2'd2, 8'h00, 8'h00, 32'h0));
        drain_results();
    endtask

    task automatic test_ring_overflow();
        for (int i = 0; i < EVENT_DEPTH + 2; i++)
            send_item(make_item(MODE_SAMPLE, 2'd2, (i % 2 == 0) ? 8'h00 : 8'hFF, 8'h00,
                                32'(i)));
        send_item(make_item(MODE_POP, 2'd0, 8'h00, 8'h00, 32'h0));
        send_item(make_item(MODE_NONE, 2'd0, 8'h00, 8'h00, 32'h0));
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [PORT_COUNT-1:0][LEVEL_W-1:0] masks;
        int pop_pct [8];
        pop_pct = '{20, 30, 45, 10, 35, 60, 25, 30};
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0, 7: masks = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
                1:    masks = '0;
                3:    masks = {8'h80, 8'h10, 8'h02, 8'h01};
                4:    masks = {8'h00, 8'hFF, 8'h00, 8'hFF};
                default:
                begin
                    for (int p = 0; p < PORT_COUNT; p++)
                        masks[p] = LEVEL_W'($urandom);
                end
            endcase
            set_listen_masks(masks, phase % 2 == 1);
            quiet = (phase == 7);
            repeat (250)
                send_item(random_item(pop_pct[phase]));
            drain_results();
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_SAMPLE;
        item_ch.port_index  = '0;
        item_ch.pin_levels  = '0;
        item_ch.resync_mask = '0;
        item_ch.sample_time = '0;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            listen_mask[p] = '0;
            last_seen[p]   = '0;
        end
        ring_head       = 0;
        ring_count      = 0;
        error_count     = 0;
        items_sent      = 0;
        reports_checked = 0;
        pops_with_event = 0;
        overflow_count  = 0;
        mask_settings   = 0;
        quiet           = 1'b0;
        stamp_clock     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_basic_events();
        test_ring_overflow();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d transactions over %0d listen mask settings.",
                 reports_checked, items_sent, mask_settings);
        $display("Events popped: %0d, oldest events overwritten on a full ring: %0d.",
                 pops_with_event, overflow_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pcef_pkg.sv
rtl/core/pcef_ifs.sv
rtl/core/pcef_ring.sv
rtl/core/pin_change_event_fifo.sv
bench/tb_pin_change_event_fifo.sv
